// File: design/assert_macros.svh
// Assertion macros for the block's RTL files.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/mi4_pkg.sv
// Package of the 4x4 matrix inverse unit: word types, constants, index helpers.
// No dependencies.
package mi4_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DIM_ELEMS     = 16;

   typedef struct packed {
      logic [1:0]         col_index;
      logic [1:0]         row_index;
      logic signed [31:0] elem_value;
      logic               start_invert;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_col;
      logic [1:0]         out_row;
      logic signed [31:0] inv_value;
      logic               singular;
      logic               saturated;
      logic               last_out;
   } rsp_type;

   // head of the load queue, front to back
   typedef struct packed {
      logic    valid;
      req_type word;
   } queue_head_type;

   // 3x3 submatrix index of operand pos (0..2) in term t (0..5) of the rule of Sarrus
   function automatic logic [3:0] sub_index(input logic [2:0] t, input logic [1:0] pos);
      logic [3:0] k;
      case ({t, pos})
         5'b000_00: k = 4'd0;
         5'b000_01: k = 4'd4;
         5'b000_10: k = 4'd8;
         5'b001_00: k = 4'd1;
         5'b001_01: k = 4'd5;
         5'b001_10: k = 4'd6;
         5'b010_00: k = 4'd2;
         5'b010_01: k = 4'd3;
         5'b010_10: k = 4'd7;
         5'b011_00: k = 4'd6;
         5'b011_01: k = 4'd4;
         5'b011_10: k = 4'd2;
         5'b100_00: k = 4'd7;
         5'b100_01: k = 4'd5;
         5'b100_10: k = 4'd0;
         5'b101_00: k = 4'd8;
         5'b101_01: k = 4'd3;
         5'b101_10: k = 4'd1;
         default:   k = 4'd0;
      endcase
      return k;
   endfunction

   // store address {row, col} of submatrix element k for the minor that drops (r, c)
   function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [3:0] k);
      logic [1:0] si;
      logic [1:0] sj;
      logic [1:0] row;
      logic [1:0] col;
      case (k)
         4'd0: begin si = 2'd0; sj = 2'd0; end
         4'd1: begin si = 2'd0; sj = 2'd1; end
         4'd2: begin si = 2'd0; sj = 2'd2; end
         4'd3: begin si = 2'd1; sj = 2'd0; end
         4'd4: begin si = 2'd1; sj = 2'd1; end
         4'd5: begin si = 2'd1; sj = 2'd2; end
         4'd6: begin si = 2'd2; sj = 2'd0; end
         4'd7: begin si = 2'd2; sj = 2'd1; end
         4'd8: begin si = 2'd2; sj = 2'd2; end
         default: begin si = 2'd0; sj = 2'd0; end
      endcase
      row = (si >= r) ? si + 2'd1 : si;
      col = (sj >= c) ? sj + 2'd1 : sj;
      return {row, col};
   endfunction

endpackage

// File: design/matrix_inverse_4x4_unit.sv
// 4x4 matrix inverse by the adjugate, signed fixed point with saturation.
// Loads: one word per cycle into a two-word queue; busy only when it is full.
// Inversion: 16 cofactors x 6 terms, then the determinant, then 16 divisions
// with FRAC_BITS fraction bits (Q16.16 by default), computed on the single
// shared 32x32 multiplier and the one-bit-a-cycle divider.
// Sync reset clears the store and the queue; results cannot be stalled.
module matrix_inverse_4x4_unit import mi4_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   queue_head_type q_head;
   logic           q_pop;

   mi4_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   mi4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// File: design/mi4_front.sv
// Front end: accepts load words and queues them for the back end.
// Depends on mi4_pkg.
module mi4_front import mi4_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type        req_word,
   output queue_head_type q_head,
   input  logic           q_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   req_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           push;

   assign busy   = (fill_ff == FW'(QUEUE_DEPTH));
   assign push   = start && !busy;
   assign q_head = '{valid: (fill_ff != '0), word: slot_ff[rd_ptr_ff]};

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (!push && q_pop) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

// File: design/mi4_back.sv
// Back end: matrix store, cofactor / determinant sequencer over one shared
// 32x32 multiplier, and a restoring divider producing the inverse words.
// Depends on mi4_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mi4_back import mi4_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           q_pop,
   output logic           rsp_strobe,
   output rsp_type        rsp_word
);

   localparam int ITER = 64 + FRAC_BITS;
   localparam int IW   = $clog2(ITER);
   localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] VMAX_WIDE = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LD1  = 4'd1;
   localparam logic [3:0] S_LD2  = 4'd2;
   localparam logic [3:0] S_LD3  = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_MULF = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_LDD  = 4'd7;
   localparam logic [3:0] S_DIVI = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_DFIN = 4'd10;
   localparam logic [3:0] S_SING = 4'd11;

   // saturating add on the 64-bit range
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b,
                                              output logic ovf);
      logic signed [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      ovf = 1'b0;
      if (sum > VMAX_WIDE) begin
         ovf = 1'b1;
         return VMAX;
      end else if (sum < -VMAX_WIDE) begin
         ovf = 1'b1;
         return -VMAX;
      end
      return sum[63:0];
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   logic [31:0]        store_ff [DIM_ELEMS];
   logic signed [63:0] cof_ff   [DIM_ELEMS];
   logic               csat_ff  [DIM_ELEMS];

   logic [3:0]         state_ff, state_in;
   logic [3:0]         idx_ff, idx_in;
   logic [2:0]         t_ff, t_in;
   logic               second_ff, second_in;
   logic               det_mode_ff, det_mode_in;
   logic [1:0]         mcnt_ff, mcnt_in;
   logic               sat_ff, sat_in;
   logic               dsat_ff, dsat_in;
   logic signed [63:0] s_ff, s_in;
   logic signed [63:0] det_ff, det_in;
   logic signed [63:0] opa_ff, opa_in;
   logic signed [63:0] opb_ff, opb_in;
   logic [127:0]       acc_ff, acc_in;
   logic signed [63:0] p_ff, p_in;
   logic [63:0]        nsh_ff, nsh_in;
   logic [63:0]        rem_ff, rem_in;
   logic [40:0]        quo_ff, quo_in;
   logic               big_ff, big_in;
   logic               dneg_ff, dneg_in;
   logic [IW-1:0]      it_ff, it_in;
   logic               strobe_in;
   rsp_type            word_ff, word_in;
   logic               strobe_ff;

   logic               cof_we;
   logic signed [63:0] cof_wd;
   logic               csat_wd;

   // element fetch for the current minor
   logic [1:0]         ld_pos;
   logic [3:0]         ld_addr;
   logic signed [63:0] elem;
   logic signed [63:0] cof_rd;

   always_comb begin
      ld_pos  = (state_ff == S_LD1) ? 2'd0 : ((state_ff == S_LD2) ? 2'd1 : 2'd2);
      ld_addr = elem_addr(idx_ff[3:2], idx_ff[1:0], sub_index(t_ff, ld_pos));
      if (state_ff == S_LDD) begin
         ld_addr = {2'd0, idx_ff[1:0]};
      end
      elem   = 64'(signed'(store_ff[ld_addr]));
      cof_rd = cof_ff[idx_ff];
   end

   // one 32x32 partial product per cycle
   logic [63:0]  ua, ub;
   logic [31:0]  ah, bh;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic         mneg;

   always_comb begin
      ua    = mag(opa_ff);
      ub    = mag(opb_ff);
      mneg  = opa_ff[63] ^ opb_ff[63];
      ah    = mcnt_ff[0] ? ua[63:32] : ua[31:0];
      bh    = mcnt_ff[1] ? ub[63:32] : ub[31:0];
      pp    = 64'(ah) * 64'(bh);
      pp_sh = {64'd0, pp} << (7'(mcnt_ff[0]) * 7'd32 + 7'(mcnt_ff[1]) * 7'd32);
   end

   // rounding and saturation of the product
   logic [127:0]       rnd_full;
   logic [127:0]       rnd_q;
   logic               m_ovf;
   logic signed [63:0] m_res;

   always_comb begin
      rnd_full = acc_ff + (128'd1 << (FRAC_BITS - 1));
      rnd_q    = rnd_full >> FRAC_BITS;
      m_ovf    = |rnd_q[127:63];
      m_res    = m_ovf ? VMAX : signed'(rnd_q[63:0]);
      if (mneg) begin
         m_res = -m_res;
      end
   end

   // accumulate step
   logic signed [63:0] addend;
   logic signed [63:0] s_new;
   logic               a_ovf;

   always_comb begin
      addend = (det_mode_ff || t_ff < 3'd3) ? p_ff : -p_ff;
      s_new  = sadd(s_ff, addend, a_ovf);
   end

   // restoring divider step and final rounding
   logic [64:0] rn;
   logic        rge;
   logic [40:0] qs;
   logic        rbit;
   logic [41:0] qf;
   logic [63:0] dmag;
   logic [31:0] dv;
   logic        dclip;

   always_comb begin
      dmag = mag(det_ff);
      rn   = {rem_ff, nsh_ff[63]};
      rge  = (rn >= {1'b0, dmag});
      qs   = quo_ff[40] ? quo_ff : {quo_ff[39:0], 1'b0};
      if (rge) begin
         qs[0] = 1'b1;
      end
      rbit  = ({rem_ff, 1'b0} >= {1'b0, dmag});
      qf    = {1'b0, quo_ff} + 42'(rbit);
      dclip = 1'b0;
      if (!dneg_ff) begin
         if (big_ff || qf > 42'h07FFFFFFF) begin
            dclip = 1'b1;
            dv    = 32'h7FFFFFFF;
         end else begin
            dv = qf[31:0];
         end
      end else begin
         if (big_ff || qf > 42'h080000000) begin
            dclip = 1'b1;
            dv    = 32'h80000000;
         end else begin
            dv = 32'(-qf[31:0]);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      t_in        = t_ff;
      second_in   = second_ff;
      det_mode_in = det_mode_ff;
      mcnt_in     = mcnt_ff;
      sat_in      = sat_ff;
      dsat_in     = dsat_ff;
      s_in        = s_ff;
      det_in      = det_ff;
      opa_in      = opa_ff;
      opb_in      = opb_ff;
      acc_in      = acc_ff;
      p_in        = p_ff;
      nsh_in      = nsh_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      big_in      = big_ff;
      dneg_in     = dneg_ff;
      it_in       = it_ff;
      strobe_in   = 1'b0;
      word_in     = word_ff;
      q_pop       = 1'b0;
      cof_we      = 1'b0;
      cof_wd      = (idx_ff[2] ^ idx_ff[0]) ? -s_new : s_new;
      csat_wd     = sat_ff | a_ovf;

      case (state_ff)
         S_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.word.start_invert) begin
                  idx_in      = '0;
                  t_in        = '0;
                  s_in        = '0;
                  sat_in      = 1'b0;
                  det_mode_in = 1'b0;
                  state_in    = S_LD1;
               end
            end
         end
         S_LD1: begin
            opa_in   = elem;
            state_in = S_LD2;
         end
         S_LD2: begin
            opb_in    = elem;
            second_in = 1'b0;
            mcnt_in   = '0;
            acc_in    = '0;
            state_in  = S_MUL;
         end
         S_LD3: begin
            opa_in    = p_ff;
            opb_in    = elem;
            second_in = 1'b1;
            mcnt_in   = '0;
            acc_in    = '0;
            state_in  = S_MUL;
         end
         S_LDD: begin
            opa_in   = elem;
            opb_in   = cof_rd;
            mcnt_in  = '0;
            acc_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in  = acc_ff + pp_sh;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = S_MULF;
            end
         end
         S_MULF: begin
            p_in   = m_res;
            sat_in = sat_ff | m_ovf;
            if (!det_mode_ff && !second_ff) begin
               state_in = S_LD3;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (det_mode_ff) begin
               if (idx_ff[1:0] == 2'd3) begin
                  det_in  = s_new;
                  dsat_in = sat_ff | a_ovf;
                  idx_in  = '0;
                  state_in = (s_new == 64'sd0) ? S_SING : S_DIVI;
               end else begin
                  s_in     = s_new;
                  sat_in   = sat_ff | a_ovf;
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_LDD;
               end
            end else if (t_ff == 3'd5) begin
               cof_we = 1'b1;
               t_in   = '0;
               s_in   = '0;
               sat_in = 1'b0;
               if (idx_ff == 4'd15) begin
                  idx_in      = '0;
                  det_mode_in = 1'b1;
                  state_in    = S_LDD;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_LD1;
               end
            end else begin
               t_in     = t_ff + 3'd1;
               s_in     = s_new;
               sat_in   = sat_ff | a_ovf;
               state_in = S_LD1;
            end
         end
         S_DIVI: begin
            nsh_in   = mag(cof_rd);
            dneg_in  = cof_rd[63] ^ det_ff[63];
            rem_in   = '0;
            quo_in   = '0;
            big_in   = 1'b0;
            it_in    = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            nsh_in = {nsh_ff[62:0], 1'b0};
            rem_in = rge ? 64'(rn - {1'b0, dmag}) : rn[63:0];
            quo_in = qs;
            big_in = big_ff | quo_ff[40];
            it_in  = it_ff + IW'(1);
            if (it_ff == IW'(ITER - 1)) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            strobe_in = 1'b1;
            word_in   = '{out_col: idx_ff[3:2], out_row: idx_ff[1:0], inv_value: signed'(dv),
                          singular: 1'b0, saturated: dsat_ff | csat_ff[idx_ff] | dclip,
                          last_out: (idx_ff == 4'd15)};
            idx_in    = idx_ff + 4'd1;
            state_in  = (idx_ff == 4'd15) ? S_IDLE : S_DIVI;
         end
         S_SING: begin
            strobe_in = 1'b1;
            word_in   = '{out_col: idx_ff[3:2], out_row: idx_ff[1:0], inv_value: 32'sd0,
                          singular: 1'b1, saturated: 1'b0, last_out: (idx_ff == 4'd15)};
            idx_in    = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      t_ff        <= t_in;
      second_ff   <= second_in;
      det_mode_ff <= det_mode_in;
      mcnt_ff     <= mcnt_in;
      sat_ff      <= sat_in;
      dsat_ff     <= dsat_in;
      s_ff        <= s_in;
      det_ff      <= det_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      nsh_ff      <= nsh_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      big_ff      <= big_in;
      dneg_ff     <= dneg_in;
      it_ff       <= it_in;
      word_ff     <= word_in;
   end

   // matrix store, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < DIM_ELEMS; e++) begin
            store_ff[e] <= '0;
         end
      end else if (q_pop) begin
         store_ff[{q_head.word.row_index, q_head.word.col_index}] <= q_head.word.elem_value;
      end
   end

   // cofactor store
   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_ff[idx_ff]  <= cof_wd;
         csat_ff[idx_ff] <= csat_wd;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

   `ASSERT_AT(a_strobe_src, clock, reset,
      strobe_ff |-> ($past(state_ff) == S_DFIN || $past(state_ff) == S_SING),
      "result word without an emitting step")
   `ASSERT_AT(a_last_idle, clock, reset,
      (strobe_ff && word_ff.last_out) |-> (state_ff == S_IDLE),
      "sequencer still running after last word")
   `ASSERT_AT(a_sing_det, clock, reset,
      (strobe_ff && word_ff.singular) |-> (det_ff == 64'sd0),
      "singular word with nonzero determinant")

endmodule
